[rtl/mdb_pkg.sv]
// mdb_pkg: types and constants shared by the 2x2 box-filter mip downsampler
// holds the beat structs, config register indexes and reset values
// no dependencies
package mdb_pkg;

  // default depth of the line store
  localparam int unsigned MaxWidthDef = 4096;

  // register field widths
  localparam int unsigned CfgWidthW  = 13;
  localparam int unsigned CfgHeightW = 16;
  localparam int unsigned CfgChanW   = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  // width of the column compare, wide enough for line store depths up to 131071
  localparam int unsigned CmpW = 17;

  // register reset values
  localparam logic [CfgWidthW-1:0]  WidthRst  = 13'd4096;
  localparam logic [CfgHeightW-1:0] HeightRst = 16'd4096;
  localparam logic [CfgChanW-1:0]   ChanRst   = 3'd4;

  // config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH     = 2'd0,
    CFG_SRC_HEIGHT    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  // source pixel beat
  typedef struct packed {
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
    logic [7:0] in_ch3;
  } pix_in_t;

  // destination pixel beat
  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;
    logic       last_pixel;
  } pix_out_t;

endpackage

[rtl/mip_downsample_box_2x2.sv]
// A beat that completes a 2x2 block passes the stage 1 register and then the output register before it is offered.
// Throughput: one source pixel per cycle, set by the single-port-read, single-port-write
// line store (one read per pixel, a write on even rows only); stalls only when the output is held.
// Reset: counters, previous pixel and pipeline valids clear; registers return to
// width 4096, height 4096, four channels. The line store is not cleared.
// mip_downsample_box_2x2: one level of 2x2 box-filter mip downsampling, raster input
// depends on mdb_pkg
module mip_downsample_box_2x2 import mdb_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // source pixels
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_pix_i,
  // destination pixels
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_pix_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_WIDTH);

  // config registers
  logic [CfgWidthW-1:0]  cfg_width_q;
  logic [CfgHeightW-1:0] cfg_height_q;
  logic [CfgChanW-1:0]   cfg_chan_q;

  // scan state
  logic [AW-1:0]         col_q, col_d;
  logic [CfgHeightW-1:0] row_q, row_d;
  logic [31:0]           prev_px_q;

  // line store and its read pipeline
  logic [31:0] line_mem [MAX_WIDTH];
  logic [31:0] rd_q;
  logic [31:0] top_prev_q;

  // stage 1: block assembly
  logic        s1_valid_q;
  logic [31:0] s1_br_q, s1_bl_q;
  logic        s1_xodd_q, s1_yodd_q, s1_last_q;
  logic [3:0]  s1_mask_q;

  // output register
  logic     out_valid_q;
  pix_out_t out_pix_q;

  logic                  in_acc;
  logic                  s1_adv;
  logic [CmpW-1:0]       w_eff;
  logic [CfgHeightW-1:0] h_eff;
  logic [CfgChanW-1:0]   nch_eff;
  logic [3:0]            chan_mask;
  logic [31:0]           px;
  logic                  end_col, end_row, emit;
  logic [31:0]           tl, tr;
  pix_out_t              avg_pix;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthRst;
      cfg_height_q <= HeightRst;
      cfg_chan_q   <= ChanRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:     cfg_width_q  <= cfg_wdata_i[CfgWidthW-1:0];
        CFG_SRC_HEIGHT:    cfg_height_q <= cfg_wdata_i[CfgHeightW-1:0];
        CFG_CHANNEL_COUNT: cfg_chan_q   <= cfg_wdata_i[CfgChanW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry and channel mask
  always_comb begin
    w_eff = CmpW'(cfg_width_q);
    if (w_eff == '0) begin
      w_eff = CmpW'(1);
    end else if (w_eff > MaxW) begin
      w_eff = MaxW;
    end
    h_eff = (cfg_height_q == '0) ? CfgHeightW'(1) : cfg_height_q;
    nch_eff = cfg_chan_q;
    if (nch_eff == '0) begin
      nch_eff = CfgChanW'(1);
    end else if (nch_eff > CfgChanW'(4)) begin
      nch_eff = CfgChanW'(4);
    end
    for (int c = 0; c < 4; c++) begin
      chan_mask[c] = (CfgChanW'(c) < nch_eff);
    end
  end

  // masked input pixel, channel 0 in the low byte
  assign px = {in_pix_i.in_ch3 & {8{chan_mask[3]}}, in_pix_i.in_ch2 & {8{chan_mask[2]}},
               in_pix_i.in_ch1 & {8{chan_mask[1]}}, in_pix_i.in_ch0 & {8{chan_mask[0]}}};

  // block position of the incoming pixel
  assign end_col = (CmpW'(col_q) >= (w_eff - CmpW'(1)));
  assign end_row = (row_q >= (h_eff - CfgHeightW'(1)));
  assign emit    = (col_q[0] || end_col) && (row_q[0] || end_row);

  // handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // next column and row
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (end_col) begin
      col_d = '0;
      row_d = end_row ? '0 : row_q + CfgHeightW'(1);
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  // scan counters and previous pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      prev_px_q <= '0;
    end else if (in_acc) begin
      col_q     <= col_d;
      row_q     <= row_d;
      prev_px_q <= px;
    end
  end

  // line store: even rows write, every beat reads its column
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!row_q[0]) begin
        line_mem[col_q] <= px;
      end
      rd_q       <= line_mem[col_q];
      top_prev_q <= rd_q;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_br_q   <= px;
      s1_bl_q   <= col_q[0] ? prev_px_q : px;
      s1_xodd_q <= col_q[0];
      s1_yodd_q <= row_q[0];
      s1_last_q <= end_col && end_row;
      s1_mask_q <= chan_mask;
    end
  end

  // top pair of the block and the per-channel average
  assign tl = s1_yodd_q ? (s1_xodd_q ? top_prev_q : rd_q) : s1_bl_q;
  assign tr = s1_yodd_q ? rd_q : s1_br_q;

  always_comb begin
    logic [9:0] sum [4];
    logic [7:0] avg [4];
    for (int c = 0; c < 4; c++) begin
      sum[c] = 10'(tl[8*c +: 8]) + 10'(tr[8*c +: 8])
             + 10'(s1_bl_q[8*c +: 8]) + 10'(s1_br_q[8*c +: 8]);
      avg[c] = s1_mask_q[c] ? sum[c][9:2] : 8'd0;
    end
    avg_pix.out_ch0    = avg[0];
    avg_pix.out_ch1    = avg[1];
    avg_pix.out_ch2    = avg[2];
    avg_pix.out_ch3    = avg[3];
    avg_pix.last_pixel = s1_last_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_pix_q <= avg_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  // input stalls only when both pipeline stages are full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // a beat ending a row restarts the column count
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_col) |=> (col_q == '0))
    else $error("column count did not wrap at row end");

  // the column count steps by one inside a row
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !end_col) |=> (col_q == $past(col_q) + AW'(1)))
    else $error("column count skipped");

  // unused top channel comes out as zero
  a_unused_ch3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (nch_eff < CfgChanW'(4))) |-> (out_pix_o.out_ch3 == 8'd0))
    else $error("unused channel 3 not zero");

endmodule
